[src/cnms_pkg.sv]
package cnms_pkg;

  // Field widths of the pixel and result requests.
  localparam int IntBits = 11;
  localparam int DirBits = 3;
  localparam int RowBits = 12;
  localparam int ColBits = 10;

  // Configuration port.
  localparam int CfgIdxBits  = 8;
  localparam int CfgDataBits = 12;
  localparam int CfgWidthBits  = 11;
  localparam int CfgHeightBits = 12;

  localparam logic [CfgIdxBits-1:0] CfgImageWidth  = 8'd0;
  localparam logic [CfgIdxBits-1:0] CfgImageHeight = 8'd1;

  localparam int WidthRst  = 640;
  localparam int HeightRst = 480;
  localparam int MinSide   = 3;

  // Direction codes. Codes above DirDiag are invalid.
  localparam logic [DirBits-1:0] DirNone = 3'd0;
  localparam logic [DirBits-1:0] DirVert = 3'd1;
  localparam logic [DirBits-1:0] DirHorz = 3'd2;
  localparam logic [DirBits-1:0] DirAnti = 3'd3;
  localparam logic [DirBits-1:0] DirDiag = 3'd4;

  // Result slots that one pixel can cause, in emission order.
  localparam int NumSlots  = 4;
  localparam int SlotCtr   = 0;  // centre one row up, one column left
  localparam int SlotRowE  = 1;  // right border pixel of the previous row
  localparam int SlotLastR = 2;  // bottom border pixel, one column left
  localparam int SlotCorn  = 3;  // bottom right corner, end of frame

  typedef struct packed {
    logic [IntBits-1:0] intensity;
    logic [DirBits-1:0] direction;
  } in_t;

  typedef struct packed {
    logic [IntBits-1:0] out_value;
    logic [RowBits-1:0] out_row;
    logic [ColBits-1:0] out_col;
    logic               bad_direction;
    logic               last_of_run;
    logic               frame_end;
  } out_t;

  // Everything one pixel hands to the result sequencer.
  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [IntBits-1:0]  value;
    logic                bad;
    logic [RowBits-1:0]  row_up;
    logic [RowBits-1:0]  row_last;
    logic [ColBits-1:0]  col_left;
    logic [ColBits-1:0]  col_last;
  } run_t;

endpackage

[src/cnms_result_seq.sv]
module cnms_result_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           run_valid_i,
  input  cnms_pkg::run_t run_i,
  output logic           run_ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cnms_pkg::out_t out_data_o
);

  localparam int NumSlots = cnms_pkg::NumSlots;

  cnms_pkg::run_t      run_q;
  logic [NumSlots-1:0] pend_q, pend_d;
  logic [NumSlots-1:0] first, rest;
  logic                out_fire, load;

  // Lowest pending slot goes out first.
  assign first    = pend_q & (~pend_q + NumSlots'(1));
  assign rest     = pend_q & ~first;
  assign out_valid_o = |pend_q;
  assign out_fire = out_valid_o && !out_stall_i;
  assign run_ready_o = (pend_q == '0) || (out_fire && (rest == '0));
  assign load     = run_valid_i && run_ready_o;

  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d = run_i.mask;
    end else if (out_fire) begin
      pend_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_q <= run_i;
    end
  end

  always_comb begin
    out_data_o               = '0;
    out_data_o.last_of_run   = (rest == '0);
    if (first[cnms_pkg::SlotCtr]) begin
      out_data_o.out_value     = run_q.value;
      out_data_o.bad_direction = run_q.bad;
      out_data_o.out_row       = run_q.row_up;
      out_data_o.out_col       = run_q.col_left;
    end else if (first[cnms_pkg::SlotRowE]) begin
      out_data_o.out_row = run_q.row_up;
      out_data_o.out_col = run_q.col_last;
    end else if (first[cnms_pkg::SlotLastR]) begin
      out_data_o.out_row = run_q.row_last;
      out_data_o.out_col = run_q.col_left;
    end else begin
      out_data_o.out_row   = run_q.row_last;
      out_data_o.out_col   = run_q.col_last;
      out_data_o.frame_end = first[cnms_pkg::SlotCorn];
    end
  end

endmodule

[src/canny_non_max_suppression_core.sv]
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_stall_o     cnms_pkg::in_t  (intensity, direction)
// out      output     out_valid_o / out_stall_i   cnms_pkg::out_t (value, row, col, flags)
// cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// A pixel request enters the compare stage as its line memory word is read synchronously;
// there it is compared and its results go to the sequencer. Pixels that cause at most one
// result are accepted one per cycle unless the output stalls; row 0 pixels cause none. From
// row 1 on, a pixel at the end of a row causes two results, as does every pixel from column
// 1 on in the last row, and the pixel at the end of the last row causes four. The single
// output port sends one per cycle unless stalled, so those pixels hold the input longer.
// Reset clears counters, window and control state; the line memory is not cleared.
// A stall on the output backs up through the compare stage to in_stall_o in the same cycle.
module canny_non_max_suppression_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  cnms_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output cnms_pkg::out_t                       out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cnms_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [cnms_pkg::CfgDataBits-1:0]     cfg_data_i
);

  localparam int IntW  = cnms_pkg::IntBits;
  localparam int DirW  = cnms_pkg::DirBits;
  localparam int RowW  = cnms_pkg::RowBits;
  localparam int OColW = cnms_pkg::ColBits;
  localparam int CfgWW = cnms_pkg::CfgWidthBits;
  localparam int CfgHW = cnms_pkg::CfgHeightBits;
  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WidthRstEff =
    (cnms_pkg::WidthRst > MAX_WIDTH) ? MAX_WIDTH : cnms_pkg::WidthRst;
  localparam int MinLast = cnms_pkg::MinSide - 1;

  // One line memory word holds both intensity rows and the direction of one column.
  typedef struct packed {
    logic [IntW-1:0] top;
    logic [IntW-1:0] mid;
    logic [DirW-1:0] dir;
  } line_t;

  // Frame geometry, kept as last index of a row and of a column.
  logic [ColW-1:0] w_last_q;
  logic [RowW-1:0] h_last_q;
  logic [CfgWW-1:0] cfg_w;
  logic [CfgHW-1:0] cfg_h;
  logic             cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cfg_w       = cfg_data_i[CfgWW-1:0];
  assign cfg_h       = cfg_data_i[CfgHW-1:0];

  // Out-of-range sizes saturate at write time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= ColW'(WidthRstEff - 1);
      h_last_q <= RowW'(cnms_pkg::HeightRst - 1);
    end else if (cfg_fire) begin
      if (cfg_index_i == cnms_pkg::CfgImageWidth) begin
        if (int'(cfg_w) < cnms_pkg::MinSide) begin
          w_last_q <= ColW'(MinLast);
        end else if (int'(cfg_w) > MAX_WIDTH) begin
          w_last_q <= ColW'(MAX_WIDTH - 1);
        end else begin
          w_last_q <= ColW'(cfg_w - CfgWW'(1));
        end
      end else if (cfg_index_i == cnms_pkg::CfgImageHeight) begin
        if (int'(cfg_h) < cnms_pkg::MinSide) begin
          h_last_q <= RowW'(MinLast);
        end else begin
          h_last_q <= cfg_h - CfgHW'(1);
        end
      end
    end
  end

  // Raster position of the next pixel. A write to a known register restarts the frame.
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic            in_fire, row_end, last_row, cfg_restart;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign row_end     = (col_q == w_last_q);
  assign last_row    = (row_q == h_last_q);
  assign cfg_restart = cfg_fire && ((cfg_index_i == cnms_pkg::CfgImageWidth) ||
                                    (cfg_index_i == cnms_pkg::CfgImageHeight));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_restart) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // Compare stage: the pixel waits here while its line memory word is read.
  logic            s1_valid_q;
  logic [IntW-1:0] s1_bot_q;
  logic [DirW-1:0] s1_dir_q;
  logic [ColW-1:0] s1_addr_q;
  logic [RowW-1:0] s1_row_up_q;
  logic [ColW-1:0] s1_col_left_q;
  logic            s1_r1_q, s1_r2_q, s1_c1_q, s1_c2_q, s1_row_end_q, s1_last_row_q;
  logic            retire, seq_ready;

  assign retire     = s1_valid_q && seq_ready;
  assign in_stall_o = s1_valid_q && !seq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (retire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bot_q      <= in_data_i.intensity;
      s1_dir_q      <= in_data_i.direction;
      s1_addr_q     <= col_q;
      s1_row_up_q   <= row_q - RowW'(1);
      s1_col_left_q <= col_q - ColW'(1);
      s1_r1_q       <= (row_q != '0);
      s1_r2_q       <= (row_q > RowW'(1));
      s1_c1_q       <= (col_q != '0);
      s1_c2_q       <= (col_q > ColW'(1));
      s1_row_end_q  <= row_end;
      s1_last_row_q <= last_row;
    end
  end

  // Line memory: read when a pixel enters, written back when it leaves the compare stage.
  // Within a frame, two pixels in flight always sit in different columns, so the read of one
  // never meets the write of the other at the same entry.
  line_t line_mem [MAX_WIDTH];
  line_t rd_q;
  line_t wr_word;

  assign wr_word.top = rd_q.mid;
  assign wr_word.mid = s1_bot_q;
  assign wr_word.dir = s1_dir_q;

  always_ff @(posedge clk_i) begin
    if (retire) begin
      line_mem[s1_addr_q] <= wr_word;
    end
    if (in_fire) begin
      rd_q <= line_mem[col_q];
    end
  end

  // 3x3 window. Entries 0..2 are column c-2 (top, middle, bottom), 3..5 column c-1.
  logic [IntW-1:0] win_q [6];
  logic [DirW-1:0] cdir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      cdir_q <= cnms_pkg::DirNone;
    end else if (retire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= rd_q.top;
      win_q[4] <= rd_q.mid;
      win_q[5] <= s1_bot_q;
      cdir_q   <= rd_q.dir;
    end
  end

  // Suppression of the centre pixel along its gradient direction. Ties keep the centre.
  logic [IntW-1:0] nb_p, nb_q, centre;
  logic            do_cmp, bad_code, keep, interior;

  assign centre   = win_q[4];
  assign interior = s1_r2_q && s1_c2_q;

  always_comb begin
    nb_p     = '0;
    nb_q     = '0;
    do_cmp   = 1'b1;
    bad_code = 1'b0;
    case (cdir_q)
      cnms_pkg::DirVert: begin
        nb_p = win_q[3];
        nb_q = win_q[5];
      end
      cnms_pkg::DirHorz: begin
        nb_p = win_q[1];
        nb_q = rd_q.mid;
      end
      cnms_pkg::DirAnti: begin
        nb_p = rd_q.top;
        nb_q = win_q[2];
      end
      cnms_pkg::DirDiag: begin
        nb_p = win_q[0];
        nb_q = s1_bot_q;
      end
      cnms_pkg::DirNone: begin
        do_cmp = 1'b0;
      end
      default: begin
        do_cmp   = 1'b0;
        bad_code = 1'b1;
      end
    endcase
  end

  assign keep = interior && do_cmp && (centre >= nb_p) && (centre >= nb_q);

  cnms_pkg::run_t run;

  always_comb begin
    run                          = '0;
    run.mask[cnms_pkg::SlotCtr]  = s1_r1_q && s1_c1_q;
    run.mask[cnms_pkg::SlotRowE] = s1_row_end_q && s1_r1_q;
    run.mask[cnms_pkg::SlotLastR] = s1_last_row_q && s1_c1_q;
    run.mask[cnms_pkg::SlotCorn] = s1_last_row_q && s1_row_end_q;
    run.value    = keep ? centre : '0;
    run.bad      = interior && bad_code;
    run.row_up   = s1_row_up_q;
    run.row_last = h_last_q;
    run.col_left = OColW'(s1_col_left_q);
    run.col_last = OColW'(w_last_q);
  end

  cnms_result_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (s1_valid_q),
    .run_i       (run),
    .run_ready_o (seq_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/cnms_checker.sv]
module cnms_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input cnms_pkg::out_t out_data_o
);

  // A stalled result request holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The end of a frame always closes the run of its pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.last_of_run &&
      (out_data_o.out_value == '0))
    else $error("frame end result malformed");

  // An invalid direction always suppresses the pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_direction |-> (out_data_o.out_value == '0))
    else $error("invalid direction passed a value");

  // The results of one pixel follow each other without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("gap inside a run of results");

  // A pixel request is only held off while a result request waits on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind canny_non_max_suppression_core cnms_checker u_cnms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
